[rtl/jedf_pkg.sv]
// Shared types, codes and helpers for the joystick event deadzone filter.
// No dependencies; every other file of the block uses this package.
package jedf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 64;
    localparam int DIVR_W    = 32;
    localparam int QCAP_W    = 41;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_XY_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XY_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUDDER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BASE = 3'd4;

    // input event types
    localparam logic [4:0] EV_SYNC = 5'd0;
    localparam logic [4:0] EV_KEY  = 5'd1;
    localparam logic [4:0] EV_AXIS = 5'd3;
    localparam logic [4:0] EV_MISC = 5'd4;

    // input commands
    localparam logic CMD_SETUP = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // result types
    localparam logic [1:0] OUT_SYNC = 2'd0;
    localparam logic [1:0] OUT_KEY  = 2'd1;
    localparam logic [1:0] OUT_AXIS = 2'd3;

    // axis indexes of the offline pattern
    localparam int AX_X        = 0;
    localparam int AX_Y        = 1;
    localparam int AX_RUDDER   = 5;
    localparam int AX_THROTTLE = 6;

    typedef struct packed {
        logic signed [31:0] cur;
        logic signed [31:0] sent;
    } axis_val_t;

    typedef struct packed {
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic signed [31:0] dlo;
        logic signed [31:0] dhi;
    } axis_zone_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [41:0] lim_hi;
        logic signed [41:0] lim_lo;
        lim_hi = 42'sd2147483647;
        lim_lo = -42'sd2147483648;
        if (v > lim_hi)
            sat32 = 32'sh7fffffff;
        else if (v < lim_lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

[rtl/jedf_if.sv]
// Channel interfaces of the joystick event deadzone filter: input, result, config.
// Depends on jedf_pkg for the register index width.
interface jedf_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [4:0]         event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic signed [31:0] axis_min;
    logic signed [31:0] axis_max;
    logic [30:0]        axis_flat;
    modport source (output valid, command, event_type, event_code, event_value,
                    axis_min, axis_max, axis_flat, input ready);
    modport sink   (input valid, command, event_type, event_code, event_value,
                    axis_min, axis_max, axis_flat, output ready);
endinterface

interface jedf_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
    modport source (output valid, out_type, out_code, out_value, last, input ready);
    modport sink   (input valid, out_type, out_code, out_value, last, output ready);
endinterface

interface jedf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jedf_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/jedf_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on jedf_pkg for widths.
module jedf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [jedf_pkg::PROD_W-1:0]   dividend,
    input  logic [jedf_pkg::DIVR_W-1:0]   divisor,
    output logic                          done,
    output logic [jedf_pkg::PROD_W-1:0]   quotient
);
    localparam int CNT_W = $clog2(jedf_pkg::PROD_W);

    logic [jedf_pkg::PROD_W-1:0] quo_reg;
    logic [jedf_pkg::DIVR_W-1:0] rem_reg;
    logic [jedf_pkg::DIVR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [jedf_pkg::DIVR_W:0]   shifted;
    logic [jedf_pkg::DIVR_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[jedf_pkg::PROD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(jedf_pkg::PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[jedf_pkg::DIVR_W])
            begin
                rem_reg <= trial[jedf_pkg::DIVR_W-1:0];
                quo_reg <= {quo_reg[jedf_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[jedf_pkg::DIVR_W-1:0];
                quo_reg <= {quo_reg[jedf_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/joystick_event_deadzone_filter.sv]
// Joystick event deadzone filter, top level.
// Depends on jedf_pkg, the channel interfaces in jedf_if.sv and jedf_div.
//
// Usage:
//   in_ch  : setup items (command 0) and input events (command 1), valid/ready.
//   out_ch : result transactions (axis changes, key changes, closing sync
//            with last = 1), held in one output register.
//   cfg    : register writes (index, data), always ready.
// Sequencing:
//   Axis setup and axis events do a read, then a write-back (read-modify-write
//   of the axis memory). Key events and ignored items are handled at accept.
//   A sync scans every axis, then every key, unless the offline pattern
//   holds: an unchanged axis is read and compared, a changed axis that needs
//   no scaling (inside its deadzone or zero divisor) is then sent, a scaled
//   axis takes one 32x32 multiply and the bit-serial divider before it is
//   sent; then the keys and the closing sync follow. Input is taken only when idle.
// Reset: registers take their defaults, all axis and key state reads as zero
//   (per-entry valid bits, no clearing pass). A stalled receiver holds the
//   output register and the scan waits on it; nothing is dropped.
module joystick_event_deadzone_filter #(
    parameter int NUM_AXES = 32,
    parameter int NUM_KEYS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    jedf_in_if.sink    in_ch,
    jedf_out_if.source out_ch,
    jedf_cfg_if.sink   cfg
);
    localparam int AXIS_W = $clog2(NUM_AXES);
    localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_VRD  = 10'b0000000010,   // read axis entry for an update
        S_VWB  = 10'b0000000100,   // write it back
        S_ARD  = 10'b0000001000,   // scan: read axis entry
        S_ACHK = 10'b0000010000,   // scan: compare, set up scaling
        S_MUL  = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_AOUT = 10'b0010000000,
        S_KEY  = 10'b0100000000,
        S_SYNC = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [31:0] xy_low_reg, xy_high_reg, rudder_reg, throttle_reg;
    logic [15:0]        key_base_reg;

    // latched item
    logic               it_setup_reg;
    logic [AXIS_W-1:0]  it_code_reg;
    logic signed [31:0] it_val_reg, it_min_reg, it_max_reg;
    logic [30:0]        it_flat_reg;

    // axis memories with per-entry valid bits
    jedf_pkg::axis_val_t  val_mem  [NUM_AXES];
    jedf_pkg::axis_zone_t zone_mem [NUM_AXES];
    jedf_pkg::axis_val_t  val_rd_reg;
    jedf_pkg::axis_zone_t zone_rd_reg;
    logic                 val_rdv_reg, zone_rdv_reg;
    logic [NUM_AXES-1:0]  val_vld_reg, zone_vld_reg;
    jedf_pkg::axis_val_t  va;
    jedf_pkg::axis_zone_t za;
    logic [AXIS_W-1:0]    mem_addr;
    logic                 rd_en, val_we, zone_we;
    jedf_pkg::axis_val_t  val_wdata;
    jedf_pkg::axis_zone_t zone_wdata;

    // shadow copies of the axes that the offline pattern looks at
    logic signed [31:0] sh_x_reg, sh_y_reg, sh_rud_reg, sh_thr_reg;

    // keys: small, kept in flops
    logic [7:0] cur_keys_reg  [NUM_KEYS];
    logic [7:0] sent_keys_reg [NUM_KEYS];

    // scan
    logic [AXIS_W-1:0]  aidx_reg;
    logic [KEY_W-1:0]   kidx_reg;
    logic signed [31:0] rv_reg;
    logic [31:0]        a_reg, bmag_reg, dmag_reg;
    logic               rneg_reg, scale_reg;

    // output register
    logic               out_vld_reg;
    logic [1:0]         out_type_reg;
    logic [15:0]        out_code_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic               out_free, out_load;
    logic [1:0]         ld_type;
    logic [15:0]        ld_code;
    logic signed [31:0] ld_value;
    logic               ld_last;

    logic in_acc, div_start, div_done;
    logic [jedf_pkg::PROD_W-1:0] div_quo;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_vld_reg || out_ch.ready;

    assign va = val_rdv_reg  ? val_rd_reg  : '0;
    assign za = zone_rdv_reg ? zone_rd_reg : '0;

    // ---- item decode at accept ----
    logic       code_is_axis;
    logic [16:0] key_diff;
    logic       key_hit;
    logic       offline;

    assign code_is_axis = in_ch.event_code < 16'(NUM_AXES);
    assign key_diff = {1'b0, in_ch.event_code} - {1'b0, key_base_reg};
    assign key_hit  = !key_diff[16] && (key_diff[15:0] < 16'(NUM_KEYS));
    assign offline  = (xy_low_reg <= sh_x_reg) && (sh_x_reg <= xy_high_reg) &&
                      (xy_low_reg <= sh_y_reg) && (sh_y_reg <= xy_high_reg) &&
                      (sh_rud_reg == rudder_reg) && (sh_thr_reg == throttle_reg);

    // ---- setup deadzone bounds ----
    logic signed [32:0] su_sum, su_mid;
    logic signed [33:0] su_dlo, su_dhi;

    assign su_sum = 33'(it_min_reg) + 33'(it_max_reg);
    // truncate toward zero
    assign su_mid = (su_sum + $signed({32'd0, su_sum[32]})) >>> 1;
    assign su_dlo = 34'(su_mid) - 34'({3'b000, it_flat_reg});
    assign su_dhi = 34'(su_mid) + 34'({3'b000, it_flat_reg});

    // ---- scan: deadzone setup from the read entry ----
    logic signed [32:0] v33, lo33, hi33, mn33, mx33, s33, rv33;
    logic signed [32:0] a_up, a_dn, b_sel, d_sel;
    logic               above, below, differ;

    assign v33  = 33'(va.cur);
    assign lo33 = 33'(za.dlo);
    assign hi33 = 33'(za.dhi);
    assign mn33 = 33'(za.mn);
    assign mx33 = 33'(za.mx);
    assign s33  = lo33 + hi33;
    assign rv33 = (s33 + $signed({32'd0, s33[32]})) >>> 1;
    assign above = v33 > hi33;
    assign below = !above && (v33 < lo33);
    assign a_up  = v33 - hi33;
    assign a_dn  = lo33 - v33;
    assign b_sel = above ? (mx33 - rv33) : (rv33 - mn33);
    assign d_sel = above ? (mx33 - hi33) : (lo33 - mn33);
    assign differ = va.cur != va.sent;

    // ---- scan: final value ----
    logic [jedf_pkg::QCAP_W-1:0] qc;
    logic signed [41:0]          sum42;
    logic signed [31:0]          axis_out;

    assign qc = (div_quo > jedf_pkg::PROD_W'(64'h100_0000_0000)) ?
                jedf_pkg::QCAP_W'(41'h100_0000_0000) : div_quo[jedf_pkg::QCAP_W-1:0];
    always_comb
    begin
        sum42 = 42'(rv_reg);
        if (scale_reg)
        begin
            if (rneg_reg)
                sum42 = sum42 - 42'({1'b0, qc});
            else
                sum42 = sum42 + 42'({1'b0, qc});
        end
        axis_out = jedf_pkg::sat32(sum42);
    end

    // ---- memory port control ----
    always_comb
    begin
        mem_addr   = (state_reg == S_VRD || state_reg == S_VWB) ? it_code_reg : aidx_reg;
        rd_en      = (state_reg == S_VRD) || (state_reg == S_ARD);
        val_we     = (state_reg == S_VWB) || ((state_reg == S_ACHK) && differ);
        zone_we    = (state_reg == S_VWB) && it_setup_reg;
        val_wdata  = (state_reg == S_VWB) ?
                     jedf_pkg::axis_val_t'{cur: it_val_reg, sent: va.sent} :
                     jedf_pkg::axis_val_t'{cur: va.cur, sent: va.cur};
        zone_wdata = jedf_pkg::axis_zone_t'{mn: it_min_reg, mx: it_max_reg,
                                            dlo: jedf_pkg::sat32(42'(su_dlo)),
                                            dhi: jedf_pkg::sat32(42'(su_dhi))};
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[mem_addr] <= val_wdata;
        if (zone_we)
            zone_mem[mem_addr] <= zone_wdata;
        if (rd_en)
        begin
            val_rd_reg  <= val_mem[mem_addr];
            zone_rd_reg <= zone_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_vld_reg  <= '0;
            zone_vld_reg <= '0;
            val_rdv_reg  <= 1'b0;
            zone_rdv_reg <= 1'b0;
        end
        else
        begin
            if (val_we)
                val_vld_reg[mem_addr] <= 1'b1;
            if (zone_we)
                zone_vld_reg[mem_addr] <= 1'b1;
            if (rd_en)
            begin
                val_rdv_reg  <= val_vld_reg[mem_addr];
                zone_rdv_reg <= zone_vld_reg[mem_addr];
            end
        end
    end

    // ---- divider ----
    assign div_start = (state_reg == S_MUL);

    jedf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (jedf_pkg::PROD_W'(a_reg) * jedf_pkg::PROD_W'(bmag_reg)),
        .divisor  (dmag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---- state machine ----
    logic axis_last, key_last, key_diff_now;

    assign axis_last    = aidx_reg == AXIS_W'(NUM_AXES - 1);
    assign key_last     = kidx_reg == KEY_W'(NUM_KEYS - 1);
    assign key_diff_now = cur_keys_reg[kidx_reg] != sent_keys_reg[kidx_reg];

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        ld_type    = jedf_pkg::OUT_SYNC;
        ld_code    = '0;
        ld_value   = '0;
        ld_last    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.command == jedf_pkg::CMD_SETUP)
                    begin
                        if (code_is_axis)
                            state_next = S_VRD;
                    end
                    else if (in_ch.event_type == jedf_pkg::EV_AXIS)
                    begin
                        if (code_is_axis)
                            state_next = S_VRD;
                    end
                    else if (in_ch.event_type == jedf_pkg::EV_SYNC && !offline)
                        state_next = S_ARD;
                end
            end
            S_VRD:  state_next = S_VWB;
            S_VWB:  state_next = S_IDLE;
            S_ARD:  state_next = S_ACHK;
            S_ACHK:
            begin
                if (differ)
                    state_next = ((above || below) && d_sel != '0) ? S_MUL : S_AOUT;
                else
                    state_next = axis_last ? S_KEY : S_ARD;
            end
            S_MUL:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_AOUT;
            end
            S_AOUT:
            begin
                ld_type  = jedf_pkg::OUT_AXIS;
                ld_code  = 16'(aidx_reg);
                ld_value = axis_out;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = axis_last ? S_KEY : S_ARD;
                end
            end
            S_KEY:
            begin
                ld_type  = jedf_pkg::OUT_KEY;
                ld_code  = key_base_reg + 16'(kidx_reg);
                ld_value = 32'(cur_keys_reg[kidx_reg]);
                if (!key_diff_now || out_free)
                begin
                    out_load = key_diff_now;
                    if (key_last)
                        state_next = S_SYNC;
                end
            end
            S_SYNC:
            begin
                ld_last = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            xy_low_reg   <= 32'sd510;
            xy_high_reg  <= 32'sd514;
            rudder_reg   <= 32'sd128;
            throttle_reg <= 32'sd0;
            key_base_reg <= 16'd288;
            sh_x_reg     <= '0;
            sh_y_reg     <= '0;
            sh_rud_reg   <= '0;
            sh_thr_reg   <= '0;
            aidx_reg     <= '0;
            kidx_reg     <= '0;
            out_vld_reg  <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cur_keys_reg[k]  <= '0;
                sent_keys_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    jedf_pkg::CFG_XY_LOW:   xy_low_reg   <= cfg.data;
                    jedf_pkg::CFG_XY_HIGH:  xy_high_reg  <= cfg.data;
                    jedf_pkg::CFG_RUDDER:   rudder_reg   <= cfg.data;
                    jedf_pkg::CFG_THROTTLE: throttle_reg <= cfg.data;
                    jedf_pkg::CFG_KEY_BASE: key_base_reg <= cfg.data[15:0];
                    default: ;
                endcase
            end

            // key events land straight in the key flops
            if (in_acc && in_ch.command == jedf_pkg::CMD_EVENT &&
                in_ch.event_type == jedf_pkg::EV_KEY && key_hit)
                cur_keys_reg[key_diff[KEY_W-1:0]] <= in_ch.event_value[7:0];

            if (state_reg == S_VWB)
            begin
                if (it_code_reg == AXIS_W'(jedf_pkg::AX_X))        sh_x_reg   <= it_val_reg;
                if (it_code_reg == AXIS_W'(jedf_pkg::AX_Y))        sh_y_reg   <= it_val_reg;
                if (it_code_reg == AXIS_W'(jedf_pkg::AX_RUDDER))   sh_rud_reg <= it_val_reg;
                if (it_code_reg == AXIS_W'(jedf_pkg::AX_THROTTLE)) sh_thr_reg <= it_val_reg;
            end

            if (state_reg == S_IDLE)
            begin
                aidx_reg <= '0;
                kidx_reg <= '0;
            end
            else if ((state_reg == S_ACHK && !differ) ||
                     (state_reg == S_AOUT && out_free))
                aidx_reg <= aidx_reg + 1'b1;

            if (state_reg == S_KEY && (!key_diff_now || out_free))
            begin
                if (key_diff_now)
                    sent_keys_reg[kidx_reg] <= cur_keys_reg[kidx_reg];
                kidx_reg <= kidx_reg + 1'b1;
            end

            if (out_load)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            it_setup_reg <= in_ch.command == jedf_pkg::CMD_SETUP;
            it_code_reg  <= in_ch.event_code[AXIS_W-1:0];
            it_val_reg   <= in_ch.event_value;
            it_min_reg   <= in_ch.axis_min;
            it_max_reg   <= in_ch.axis_max;
            it_flat_reg  <= in_ch.axis_flat;
        end
        if (state_reg == S_ACHK)
        begin
            rv_reg    <= rv33[31:0];
            a_reg     <= above ? a_up[31:0] : a_dn[31:0];
            bmag_reg  <= b_sel[32] ? 32'(-b_sel) : b_sel[31:0];
            dmag_reg  <= d_sel[32] ? 32'(-d_sel) : d_sel[31:0];
            rneg_reg  <= b_sel[32] ^ d_sel[32] ^ below;
            scale_reg <= (above || below) && d_sel != '0;
        end
        if (out_load)
        begin
            out_type_reg  <= ld_type;
            out_code_reg  <= ld_code;
            out_value_reg <= ld_value;
            out_last_reg  <= ld_last;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.out_type  = out_type_reg;
    assign out_ch.out_code  = out_code_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.last      = out_last_reg;

endmodule
